### hw/rtl/cmfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfu_pkg
// shared constants and types for the cube-map face and uv select pipeline
// ----------------------------------------------------------------------------
package cmfu_pkg;

  // default direction component width and coordinate fraction bits
  localparam int unsigned DEF_COMP_WIDTH   = 16;
  localparam int unsigned DEF_UV_FRAC_BITS = 16;

  // fixed output field widths
  localparam int unsigned FACE_WIDTH  = 3;
  localparam int unsigned COORD_WIDTH = 16;

  // cube faces in priority order, later member wins a magnitude tie
  typedef enum logic [FACE_WIDTH-1:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_e;

  // per-transaction side info that rides along the pipeline
  typedef struct packed {
    face_e face;
    logic  sat_u;
    logic  sat_v;
    logic  zero;
  } ctrl_t;

endpackage

### hw/rtl/cube_map_face_and_uv_select_top.sv
`timescale 1ns / 1ps
// throughput: one transaction per cycle while the output is not stalled, set by one quotient bit per divider stage
// stages: major-axis select, dividend prep, UV_FRAC_BITS divider steps, output register
// reset: rst_ni clears all valid bits asynchronously, the pipeline comes up empty
// a stalled output holds; earlier stages keep filling bubbles until they back up
// ----------------------------------------------------------------------------
// cube_map_face_and_uv_select_top
// maps a signed direction vector to a cube face and its u/v coordinates
// ----------------------------------------------------------------------------
module cube_map_face_and_uv_select_top #(
  parameter int unsigned COMP_WIDTH   = cmfu_pkg::DEF_COMP_WIDTH,
  parameter int unsigned UV_FRAC_BITS = cmfu_pkg::DEF_UV_FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [COMP_WIDTH-1:0]         dir_x_i,
  input  logic signed [COMP_WIDTH-1:0]         dir_y_i,
  input  logic signed [COMP_WIDTH-1:0]         dir_z_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [cmfu_pkg::FACE_WIDTH-1:0]      face_o,
  output logic [cmfu_pkg::COORD_WIDTH-1:0]     coord_u_o,
  output logic [cmfu_pkg::COORD_WIDTH-1:0]     coord_v_o,
  output logic                                 zero_direction_o
);

  localparam int unsigned CW = cmfu_pkg::COORD_WIDTH;
  localparam int unsigned NS = UV_FRAC_BITS;

  // major-axis stage to prep stage
  logic                       maj_valid, maj_ready;
  cmfu_pkg::ctrl_t            maj_ctrl;
  logic signed [COMP_WIDTH:0] maj_uc, maj_vc;
  logic [COMP_WIDTH-1:0]      maj_mag;

  // divider chain, index 0 is the prep stage output, index NS the last step
  logic                       st_valid [NS+1];
  logic                       st_ready [NS+1];
  cmfu_pkg::ctrl_t            st_ctrl  [NS+1];
  logic [COMP_WIDTH:0]        st_den   [NS+1];
  logic [COMP_WIDTH:0]        st_rem_u [NS+1];
  logic [COMP_WIDTH:0]        st_rem_v [NS+1];
  logic [NS-1:0]              st_quo_u [NS+1];
  logic [NS-1:0]              st_quo_v [NS+1];

  // output register
  logic                       out_valid_q;
  logic                       out_load;
  cmfu_pkg::ctrl_t            last_ctrl;
  logic [CW-1:0]              q_u_fit, q_v_fit, sat_fit;
  logic [cmfu_pkg::FACE_WIDTH-1:0] face_d, face_q;
  logic [CW-1:0]              coord_u_d, coord_u_q, coord_v_d, coord_v_q;
  logic                       zero_q;

  // stage 1: pick the major axis and the face
  cmfu_major #(
    .COMP_WIDTH (COMP_WIDTH)
  ) u_major (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .dir_z_i (dir_z_i),
    .valid_o (maj_valid),
    .ready_i (maj_ready),
    .ctrl_o  (maj_ctrl),
    .uc_o    (maj_uc),
    .vc_o    (maj_vc),
    .mag_o   (maj_mag)
  );

  // stage 2: (c + m) and 2m, saturation when the coordinate reaches one
  cmfu_prep #(
    .COMP_WIDTH   (COMP_WIDTH),
    .UV_FRAC_BITS (UV_FRAC_BITS)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (maj_valid),
    .ready_o (maj_ready),
    .ctrl_i  (maj_ctrl),
    .uc_i    (maj_uc),
    .vc_i    (maj_vc),
    .mag_i   (maj_mag),
    .valid_o (st_valid[0]),
    .ready_i (st_ready[0]),
    .ctrl_o  (st_ctrl[0]),
    .den_o   (st_den[0]),
    .rem_u_o (st_rem_u[0]),
    .rem_v_o (st_rem_v[0]),
    .quo_u_o (st_quo_u[0]),
    .quo_v_o (st_quo_v[0])
  );

  // stages 3 .. NS+2: restoring divider, msb of the fraction first
  for (genvar i = 0; i < NS; i++) begin : g_div
    cmfu_div_step #(
      .COMP_WIDTH   (COMP_WIDTH),
      .UV_FRAC_BITS (UV_FRAC_BITS)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[i]),
      .ready_o (st_ready[i]),
      .ctrl_i  (st_ctrl[i]),
      .den_i   (st_den[i]),
      .rem_u_i (st_rem_u[i]),
      .rem_v_i (st_rem_v[i]),
      .quo_u_i (st_quo_u[i]),
      .quo_v_i (st_quo_v[i]),
      .valid_o (st_valid[i+1]),
      .ready_i (st_ready[i+1]),
      .ctrl_o  (st_ctrl[i+1]),
      .den_o   (st_den[i+1]),
      .rem_u_o (st_rem_u[i+1]),
      .rem_v_o (st_rem_v[i+1]),
      .quo_u_o (st_quo_u[i+1]),
      .quo_v_o (st_quo_v[i+1])
    );
  end

  // last stage sees the output register as its downstream
  assign st_ready[NS] = !out_valid_q || out_ready_i;
  assign out_load     = st_ready[NS] && st_valid[NS];
  assign last_ctrl    = st_ctrl[NS];

  // fit the fraction to the 16-bit coordinate fields
  if (NS >= CW) begin : g_fit_trunc
    assign q_u_fit = st_quo_u[NS][CW-1:0];
    assign q_v_fit = st_quo_v[NS][CW-1:0];
    assign sat_fit = {CW{1'b1}};
  end else begin : g_fit_ext
    assign q_u_fit = CW'(st_quo_u[NS]);
    assign q_v_fit = CW'(st_quo_v[NS]);
    assign sat_fit = CW'({NS{1'b1}});
  end

  // zero vector wins over everything, then saturation, then the quotient
  always_comb begin
    face_d    = last_ctrl.face;
    coord_u_d = last_ctrl.sat_u ? sat_fit : q_u_fit;
    coord_v_d = last_ctrl.sat_v ? sat_fit : q_v_fit;
    if (last_ctrl.zero) begin
      face_d    = cmfu_pkg::FACE_NEG_Z;
      coord_u_d = '0;
      coord_v_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_ready[NS]) begin
      out_valid_q <= st_valid[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      face_q    <= face_d;
      coord_u_q <= coord_u_d;
      coord_v_q <= coord_v_d;
      zero_q    <= last_ctrl.zero;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign face_o           = face_q;
  assign coord_u_o        = coord_u_q;
  assign coord_v_o        = coord_v_q;
  assign zero_direction_o = zero_q;

endmodule

### hw/rtl/cmfu_major.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfu_major
// major-axis select: magnitudes, face choice and in-plane components
// ----------------------------------------------------------------------------
module cmfu_major #(
  parameter int unsigned COMP_WIDTH = cmfu_pkg::DEF_COMP_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [COMP_WIDTH-1:0] dir_x_i,
  input  logic signed [COMP_WIDTH-1:0] dir_y_i,
  input  logic signed [COMP_WIDTH-1:0] dir_z_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output cmfu_pkg::ctrl_t              ctrl_o,
  output logic signed [COMP_WIDTH:0]   uc_o,
  output logic signed [COMP_WIDTH:0]   vc_o,
  output logic [COMP_WIDTH-1:0]        mag_o
);

  logic signed [COMP_WIDTH:0] x_ext, y_ext, z_ext;
  logic signed [COMP_WIDTH:0] x_abs, y_abs, z_abs;
  logic [COMP_WIDTH-1:0]      ax, ay, az;
  logic                       x_major, y_major, z_major;

  logic                       valid_q;
  cmfu_pkg::ctrl_t            ctrl_d, ctrl_q;
  logic signed [COMP_WIDTH:0] uc_d, uc_q, vc_d, vc_q;
  logic [COMP_WIDTH-1:0]      mag_d, mag_q;

  // one extra bit so the most negative component negates exactly
  assign x_ext = {dir_x_i[COMP_WIDTH-1], dir_x_i};
  assign y_ext = {dir_y_i[COMP_WIDTH-1], dir_y_i};
  assign z_ext = {dir_z_i[COMP_WIDTH-1], dir_z_i};

  assign x_abs = x_ext[COMP_WIDTH] ? -x_ext : x_ext;
  assign y_abs = y_ext[COMP_WIDTH] ? -y_ext : y_ext;
  assign z_abs = z_ext[COMP_WIDTH] ? -z_ext : z_ext;

  assign ax = x_abs[COMP_WIDTH-1:0];
  assign ay = y_abs[COMP_WIDTH-1:0];
  assign az = z_abs[COMP_WIDTH-1:0];

  assign x_major = (ax >= ay) && (ax >= az);
  assign y_major = (ay >= ax) && (ay >= az);
  assign z_major = (az >= ax) && (az >= ay);

  always_comb begin
    ctrl_d       = '0;
    ctrl_d.zero  = (dir_x_i == '0) && (dir_y_i == '0) && (dir_z_i == '0);
    uc_d         = x_ext;
    vc_d         = y_ext;
    mag_d        = ax;
    ctrl_d.face  = cmfu_pkg::FACE_POS_X;
    // z beats y beats x on ties
    if (z_major) begin
      mag_d = az;
      vc_d  = y_ext;
      if (z_ext > 0) begin
        uc_d        = x_ext;
        ctrl_d.face = cmfu_pkg::FACE_POS_Z;
      end else begin
        uc_d        = -x_ext;
        ctrl_d.face = cmfu_pkg::FACE_NEG_Z;
      end
    end else if (y_major) begin
      mag_d = ay;
      uc_d  = x_ext;
      if (y_ext > 0) begin
        vc_d        = -z_ext;
        ctrl_d.face = cmfu_pkg::FACE_POS_Y;
      end else begin
        vc_d        = z_ext;
        ctrl_d.face = cmfu_pkg::FACE_NEG_Y;
      end
    end else if (x_major) begin
      mag_d = ax;
      vc_d  = y_ext;
      if (x_ext > 0) begin
        uc_d        = -z_ext;
        ctrl_d.face = cmfu_pkg::FACE_POS_X;
      end else begin
        uc_d        = z_ext;
        ctrl_d.face = cmfu_pkg::FACE_NEG_X;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctrl_q <= ctrl_d;
      uc_q   <= uc_d;
      vc_q   <= vc_d;
      mag_q  <= mag_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign uc_o    = uc_q;
  assign vc_o    = vc_q;
  assign mag_o   = mag_q;

endmodule

### hw/rtl/cmfu_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfu_prep
// builds dividend and divisor for both coordinates, flags saturation
// ----------------------------------------------------------------------------
module cmfu_prep #(
  parameter int unsigned COMP_WIDTH   = cmfu_pkg::DEF_COMP_WIDTH,
  parameter int unsigned UV_FRAC_BITS = cmfu_pkg::DEF_UV_FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  cmfu_pkg::ctrl_t              ctrl_i,
  input  logic signed [COMP_WIDTH:0]   uc_i,
  input  logic signed [COMP_WIDTH:0]   vc_i,
  input  logic [COMP_WIDTH-1:0]        mag_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output cmfu_pkg::ctrl_t              ctrl_o,
  output logic [COMP_WIDTH:0]          den_o,
  output logic [COMP_WIDTH:0]          rem_u_o,
  output logic [COMP_WIDTH:0]          rem_v_o,
  output logic [UV_FRAC_BITS-1:0]      quo_u_o,
  output logic [UV_FRAC_BITS-1:0]      quo_v_o
);

  logic signed [COMP_WIDTH+1:0] mag_s, num_u_s, num_v_s;
  logic [COMP_WIDTH:0]          num_u, num_v, den;

  logic                         valid_q;
  cmfu_pkg::ctrl_t              ctrl_d, ctrl_q;
  logic [COMP_WIDTH:0]          den_q, rem_u_q, rem_v_q;

  assign mag_s   = {2'b00, mag_i};
  // c + m lies in 0..2m
  assign num_u_s = {uc_i[COMP_WIDTH], uc_i} + mag_s;
  assign num_v_s = {vc_i[COMP_WIDTH], vc_i} + mag_s;
  assign num_u   = num_u_s[COMP_WIDTH:0];
  assign num_v   = num_v_s[COMP_WIDTH:0];
  assign den     = {mag_i, 1'b0};

  always_comb begin
    ctrl_d       = ctrl_i;
    ctrl_d.sat_u = (num_u >= den);
    ctrl_d.sat_v = (num_v >= den);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctrl_q  <= ctrl_d;
      den_q   <= den;
      rem_u_q <= num_u;
      rem_v_q <= num_v;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign den_o   = den_q;
  assign rem_u_o = rem_u_q;
  assign rem_v_o = rem_v_q;
  assign quo_u_o = '0;
  assign quo_v_o = '0;

endmodule

### hw/rtl/cmfu_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfu_div_step
// one restoring division step for u and v, one quotient bit each
// ----------------------------------------------------------------------------
module cmfu_div_step #(
  parameter int unsigned COMP_WIDTH   = cmfu_pkg::DEF_COMP_WIDTH,
  parameter int unsigned UV_FRAC_BITS = cmfu_pkg::DEF_UV_FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  cmfu_pkg::ctrl_t         ctrl_i,
  input  logic [COMP_WIDTH:0]     den_i,
  input  logic [COMP_WIDTH:0]     rem_u_i,
  input  logic [COMP_WIDTH:0]     rem_v_i,
  input  logic [UV_FRAC_BITS-1:0] quo_u_i,
  input  logic [UV_FRAC_BITS-1:0] quo_v_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output cmfu_pkg::ctrl_t         ctrl_o,
  output logic [COMP_WIDTH:0]     den_o,
  output logic [COMP_WIDTH:0]     rem_u_o,
  output logic [COMP_WIDTH:0]     rem_v_o,
  output logic [UV_FRAC_BITS-1:0] quo_u_o,
  output logic [UV_FRAC_BITS-1:0] quo_v_o
);

  logic [COMP_WIDTH+1:0]   sh_u, sh_v, den_ext, diff_u, diff_v;
  logic                    bit_u, bit_v;

  logic                    valid_q;
  cmfu_pkg::ctrl_t         ctrl_q;
  logic [COMP_WIDTH:0]     den_q, rem_u_d, rem_u_q, rem_v_d, rem_v_q;
  logic [UV_FRAC_BITS-1:0] quo_u_d, quo_u_q, quo_v_d, quo_v_q;

  assign sh_u    = {rem_u_i, 1'b0};
  assign sh_v    = {rem_v_i, 1'b0};
  assign den_ext = {1'b0, den_i};
  assign diff_u  = sh_u - den_ext;
  assign diff_v  = sh_v - den_ext;
  assign bit_u   = (sh_u >= den_ext);
  assign bit_v   = (sh_v >= den_ext);

  assign rem_u_d = bit_u ? diff_u[COMP_WIDTH:0] : sh_u[COMP_WIDTH:0];
  assign rem_v_d = bit_v ? diff_v[COMP_WIDTH:0] : sh_v[COMP_WIDTH:0];
  assign quo_u_d = {quo_u_i[UV_FRAC_BITS-2:0], bit_u};
  assign quo_v_d = {quo_v_i[UV_FRAC_BITS-2:0], bit_v};

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctrl_q  <= ctrl_i;
      den_q   <= den_i;
      rem_u_q <= rem_u_d;
      rem_v_q <= rem_v_d;
      quo_u_q <= quo_u_d;
      quo_v_q <= quo_v_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign den_o   = den_q;
  assign rem_u_o = rem_u_q;
  assign rem_v_o = rem_v_q;
  assign quo_u_o = quo_u_q;
  assign quo_v_o = quo_v_q;

endmodule
